// ----- src/sfp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the start-of-frame parser with xor check.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // width of the saturating millisecond tick counter (8 to 32)
  localparam int TICK_BITS = 16;
  localparam int TIMEOUT_BITS = 16;
  localparam int CMP_BITS = (TICK_BITS > TIMEOUT_BITS) ? TICK_BITS : TIMEOUT_BITS;

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  localparam logic [7:0] START_BYTE_RESET = 8'hFE;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(5000);

  // register byte addresses (bit 2 selects the register)
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEN   = 6'b000010,
    PH_CMDH  = 6'b000100,
    PH_CMDL  = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CHECK = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [7:0] command_high;
    logic [7:0] command_low;
    logic       check_ok;
  } out_item_t;

  typedef struct packed {
    phase_t               phase;
    logic [7:0]           length;
    logic [7:0]           cmd_high;
    logic [7:0]           cmd_low;
    logic [7:0]           xor_acc;
    logic [7:0]           count;
    logic [TICK_BITS-1:0] ticks;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]              start_byte;
    logic [TIMEOUT_BITS-1:0] timeout_ticks;
  } cfg_regs_t;

endpackage : sfp_pkg
`default_nettype wire

// ----- src/sof_frame_parser_xor_fcs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sof_frame_parser_xor_fcs
// Start-of-frame / length / command frame parser with xor frame check.
// ----------------------------------------------------------------------------
// Each input word is a received byte or a millisecond tick. When a word is
// accepted the parser state is updated at the accepting edge and any result
// (payload byte, frame end, timeout abort) lands in a single output register.
// A word can be taken every cycle; in_ready only drops while a result sits in
// the output register and out_ready is low. Results appear in the cycle after
// the word that causes them. start_byte is at address 0, timeout_ticks at 4.
module sof_frame_parser_xor_fcs (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire sfp_pkg::in_item_t in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output sfp_pkg::out_item_t out_data,
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [2:0]         cfg_paddr,
  input  wire  [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  sfp_pkg::cfg_regs_t    cfg_r;
  sfp_pkg::parse_state_t state_r;
  sfp_pkg::parse_state_t state_nxt;
  sfp_pkg::out_item_t    res;
  sfp_pkg::out_item_t    out_data_r;
  logic                  res_valid;
  logic                  out_valid_r;
  logic                  in_fire;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= sfp_pkg::START_BYTE_RESET;
      cfg_r.timeout_ticks <= sfp_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        sfp_pkg::REG_START_BYTE: cfg_r.start_byte <= cfg_pwdata[7:0];
        sfp_pkg::REG_TIMEOUT:
          cfg_r.timeout_ticks <= cfg_pwdata[sfp_pkg::TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      sfp_pkg::REG_START_BYTE: cfg_prdata = {24'd0, cfg_r.start_byte};
      sfp_pkg::REG_TIMEOUT:
        cfg_prdata = {{(32-sfp_pkg::TIMEOUT_BITS){1'b0}}, cfg_r.timeout_ticks};
      default: cfg_prdata = 32'd0;
    endcase
  end

  sfp_step u_step (
    .cur       (state_r),
    .cfg       (cfg_r),
    .item      (in_data),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= sfp_pkg::PH_IDLE;
      state_r.length   <= 8'd0;
      state_r.cmd_high <= 8'd0;
      state_r.cmd_low  <= 8'd0;
      state_r.xor_acc  <= 8'd0;
      state_r.count    <= 8'd0;
      state_r.ticks    <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : sof_frame_parser_xor_fcs
`default_nettype wire

// ----- src/sfp_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_step
// Next-state and result logic for one received byte or tick.
// ----------------------------------------------------------------------------
module sfp_step (
  input  wire sfp_pkg::parse_state_t cur,
  input  wire sfp_pkg::cfg_regs_t    cfg,
  input  wire sfp_pkg::in_item_t     item,
  output sfp_pkg::parse_state_t      nxt,
  output logic                       res_valid,
  output sfp_pkg::out_item_t         res
);

  logic [sfp_pkg::TICK_BITS-1:0] ticks_inc;
  logic [sfp_pkg::CMP_BITS-1:0]  timeout_ext;
  logic [sfp_pkg::CMP_BITS-1:0]  max_ext;
  logic [sfp_pkg::CMP_BITS-1:0]  limit;
  logic                          timed_out;
  logic [7:0]                    count_inc;

  assign ticks_inc   = (cur.ticks == sfp_pkg::TICK_MAX) ? cur.ticks
                                                        : cur.ticks + 1'b1;
  assign timeout_ext = sfp_pkg::CMP_BITS'(cfg.timeout_ticks);
  assign max_ext     = sfp_pkg::CMP_BITS'(sfp_pkg::TICK_MAX);
  assign limit       = (timeout_ext > max_ext) ? max_ext : timeout_ext;
  assign timed_out   = sfp_pkg::CMP_BITS'(ticks_inc) >= limit;
  assign count_inc   = cur.count + 8'd1;

  always_comb begin
    nxt              = cur;
    res_valid        = 1'b0;
    res.kind         = sfp_pkg::KIND_DATA;
    res.data_byte    = 8'd0;
    res.byte_index   = 8'd0;
    res.frame_length = cur.length;
    res.command_high = cur.cmd_high;
    res.command_low  = cur.cmd_low;
    res.check_ok     = 1'b0;

    if (item.mode) begin
      // ticks only matter while a frame is pending
      if (cur.phase != sfp_pkg::PH_IDLE) begin
        nxt.ticks = ticks_inc;
        if (timed_out) begin
          nxt.phase = sfp_pkg::PH_IDLE;
          res_valid = 1'b1;
          res.kind  = sfp_pkg::KIND_ABORT;
        end
      end
    end else begin
      unique case (cur.phase)
        sfp_pkg::PH_IDLE: begin
          if (item.rx_byte == cfg.start_byte) begin
            nxt.phase    = sfp_pkg::PH_LEN;
            nxt.length   = 8'd0;
            nxt.cmd_high = 8'd0;
            nxt.cmd_low  = 8'd0;
            nxt.xor_acc  = 8'd0;
            nxt.count    = 8'd0;
            nxt.ticks    = '0;
          end
        end
        sfp_pkg::PH_LEN: begin
          nxt.length  = item.rx_byte;
          nxt.xor_acc = cur.xor_acc ^ item.rx_byte;
          nxt.phase   = sfp_pkg::PH_CMDH;
        end
        sfp_pkg::PH_CMDH: begin
          nxt.cmd_high = item.rx_byte;
          nxt.xor_acc  = cur.xor_acc ^ item.rx_byte;
          nxt.phase    = sfp_pkg::PH_CMDL;
        end
        sfp_pkg::PH_CMDL: begin
          nxt.cmd_low = item.rx_byte;
          nxt.xor_acc = cur.xor_acc ^ item.rx_byte;
          // zero length goes straight to the check byte
          nxt.phase   = (cur.length == 8'd0) ? sfp_pkg::PH_CHECK : sfp_pkg::PH_DATA;
        end
        sfp_pkg::PH_DATA: begin
          res_valid      = 1'b1;
          res.kind       = sfp_pkg::KIND_DATA;
          res.data_byte  = item.rx_byte;
          res.byte_index = cur.count;
          nxt.xor_acc    = cur.xor_acc ^ item.rx_byte;
          nxt.count      = count_inc;
          if (count_inc >= cur.length) begin
            nxt.phase = sfp_pkg::PH_CHECK;
          end
        end
        sfp_pkg::PH_CHECK: begin
          res_valid    = 1'b1;
          res.kind     = sfp_pkg::KIND_END;
          res.check_ok = (cur.xor_acc == item.rx_byte);
          nxt.phase    = sfp_pkg::PH_IDLE;
        end
        default: begin
          nxt.phase = sfp_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule : sfp_step
`default_nettype wire

// ----- src/sfp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sfp_checker (
  input wire                     clk,
  input wire                     rst_n,
  input wire                     in_ready,
  input wire                     out_valid,
  input wire                     out_ready,
  input wire sfp_pkg::out_item_t out_data
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or dropped while stalled");

  // the output register never blocks input while empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == sfp_pkg::KIND_DATA ||
                   out_data.kind == sfp_pkg::KIND_END ||
                   out_data.kind == sfp_pkg::KIND_ABORT))
    else $error("illegal result kind");

  // only payload words carry a byte and index
  a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != sfp_pkg::KIND_DATA |->
      out_data.data_byte == 8'd0 && out_data.byte_index == 8'd0)
    else $error("data fields set on non-payload result");

  a_check_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.check_ok |-> out_data.kind == sfp_pkg::KIND_END)
    else $error("check flag set outside frame end");

endmodule : sfp_checker

bind sof_frame_parser_xor_fcs sfp_checker u_sfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
